/* rtl/core/gpe_pkg.sv */
// Shared types and constants for the gait phase estimator.
package gpe_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned PctW = 10;
    localparam int unsigned CoeffW = 8;
    localparam int unsigned NumHist = 3;

    localparam logic [1:0] H_STEP = 2'd0;
    localparam logic [1:0] H_STANCE = 2'd1;
    localparam logic [1:0] H_SWING = 2'd2;

    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    localparam logic [PctW-1:0] PctMax = 10'd1000;

    typedef struct packed {
        logic start;
        logic hist_start;
        logic [1:0] hist_sel;
        logic div_start;
        logic [1:0] div_sel;
    } gpe_cmd_t;

    typedef struct packed {
        logic hist_done;
        logic hist_needed;
        logic div_done;
    } gpe_stat_t;

endpackage

/* rtl/core/gait_phase_estimator_unit.sv */
// Top level of the gait phase estimator: controller plus datapath.
//
//  channel   signals                              beat
//  in        in_valid / in_ready                  now_ms, heel_contact, toe_contact
//  out       out_valid / out_ready                edge flags, expectations, percents
//  cfg       cfg_we, cfg_index, cfg_data          one register write
//
// An item runs through the history scans and then through the three 42-step
// percent divisions.
// Reset restores the coefficients to 24 and 8 and empties all histories.
// The block takes one item at a time; a result beat waits until it is taken.
module gait_phase_estimator_unit #(
    parameter int unsigned HISTORY_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [gpe_pkg::CoeffW-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gpe_pkg::TimeW-1:0]     now_ms,
    input  logic                          heel_contact,
    input  logic                          toe_contact,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          heel_strike,
    output logic                          toe_strike,
    output logic                          toe_lift,
    output logic [gpe_pkg::TimeW-1:0]     expected_step,
    output logic [gpe_pkg::TimeW-1:0]     expected_stance,
    output logic [gpe_pkg::TimeW-1:0]     expected_swing,
    output logic [gpe_pkg::PctW-1:0]      gait_percent,
    output logic [gpe_pkg::PctW-1:0]      stance_percent,
    output logic [gpe_pkg::PctW-1:0]      swing_percent
);
    import gpe_pkg::*;

    gpe_cmd_t cmd;
    gpe_stat_t stat;

    gpe_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd(cmd),
        .stat(stat)
    );

    gpe_datapath #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_index),
        .cfg_data(cfg_data),
        .now_ms(now_ms),
        .heel_contact(heel_contact),
        .toe_contact(toe_contact),
        .cmd(cmd),
        .stat(stat),
        .heel_strike(heel_strike),
        .toe_strike(toe_strike),
        .toe_lift(toe_lift),
        .expected_step(expected_step),
        .expected_stance(expected_stance),
        .expected_swing(expected_swing),
        .gait_percent(gait_percent),
        .stance_percent(stance_percent),
        .swing_percent(swing_percent)
    );
endmodule

/* rtl/core/gpe_ctrl.sv */
// Controller sequencing edge handling, history updates and percent divisions.
module gpe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gpe_pkg::gpe_cmd_t cmd,
    input  gpe_pkg::gpe_stat_t stat
);
    import gpe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HSEL = 3'd1;
    localparam logic [2:0] S_HRUN = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DRUN = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd = '0;
        cmd.hist_sel = idx_reg;
        cmd.div_sel = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    idx_next = H_STEP;
                    state_next = S_HSEL;
                end
            end
            S_HSEL:
            begin
                if (stat.hist_needed)
                begin
                    cmd.hist_start = 1'b1;
                    state_next = S_HRUN;
                end
                else if (idx_reg == H_SWING)
                begin
                    idx_next = H_STEP;
                    state_next = S_DSTART;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_HRUN:
            begin
                if (stat.hist_done)
                begin
                    if (idx_reg == H_SWING)
                    begin
                        idx_next = H_STEP;
                        state_next = S_DSTART;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        state_next = S_HSEL;
                    end
                end
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DRUN;
            end
            S_DRUN:
            begin
                if (stat.div_done)
                begin
                    if (idx_reg == H_SWING)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

/* rtl/core/gpe_datapath.sv */
// Datapath: event times, duration histories, window test, mean and divider.
module gpe_datapath #(
    parameter int unsigned HISTORY_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_idx,
    input  logic [gpe_pkg::CoeffW-1:0]    cfg_data,
    input  logic [gpe_pkg::TimeW-1:0]     now_ms,
    input  logic                          heel_contact,
    input  logic                          toe_contact,
    input  gpe_pkg::gpe_cmd_t             cmd,
    output gpe_pkg::gpe_stat_t            stat,
    output logic                          heel_strike,
    output logic                          toe_strike,
    output logic                          toe_lift,
    output logic [gpe_pkg::TimeW-1:0]     expected_step,
    output logic [gpe_pkg::TimeW-1:0]     expected_stance,
    output logic [gpe_pkg::TimeW-1:0]     expected_swing,
    output logic [gpe_pkg::PctW-1:0]      gait_percent,
    output logic [gpe_pkg::PctW-1:0]      stance_percent,
    output logic [gpe_pkg::PctW-1:0]      swing_percent
);
    import gpe_pkg::*;

    localparam int unsigned IdxW = $clog2(HISTORY_DEPTH);
    localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SumW = TimeW + $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned ProdW = TimeW + CoeffW;
    localparam int unsigned NumW = TimeW + PctW;
    localparam int unsigned DivCntW = $clog2(NumW + 1);
    localparam int unsigned DepthU = HISTORY_DEPTH;

    logic [CoeffW-1:0] upper_reg, lower_reg;
    logic last_heel_reg, last_toe_reg;
    logic hs_reg, ts_reg, to_reg;
    logic heel_reg, toe_reg;
    logic [TimeW-1:0] now_reg;
    logic [TimeW-1:0] heel_t_reg, tstr_t_reg, toff_t_reg;
    logic [1:0] heel_cnt_reg, tstr_cnt_reg, toff_cnt_reg;
    logic [TimeW-1:0] hist_reg [NumHist][HISTORY_DEPTH];
    logic [FillW-1:0] fill_reg [NumHist];
    logic [TimeW-1:0] exp_reg [NumHist];
    logic [PctW-1:0] pct_reg [NumHist];
    logic [TimeW-1:0] sample_reg [NumHist];
    logic need_reg [NumHist];

    logic [1:0] hphase_reg;
    logic [IdxW-1:0] scan_reg;
    logic [TimeW-1:0] mx_reg, mn_reg;
    logic [SumW-1:0] sum_reg;
    logic [ProdW-1:0] up_prod_reg, lo_prod_reg;
    logic accept_reg;
    logic hist_done;

    logic div_busy_reg;
    logic [DivCntW-1:0] div_cnt_reg;
    logic [NumW-1:0] div_num_reg;
    logic [TimeW:0] div_rem_reg;
    logic [TimeW-1:0] div_den_reg;
    logic div_done;

    logic hs, ts, to;
    logic [1:0] hsel, dsel;
    logic [TimeW-1:0] cur_elem;
    logic [ProdW-1:0] s16;

    assign hs = heel_contact & ~last_heel_reg;
    assign ts = toe_contact & ~last_toe_reg;
    assign to = ~toe_contact & last_toe_reg;
    assign hsel = cmd.hist_sel;
    assign dsel = cmd.div_sel;
    assign cur_elem = hist_reg[hsel][scan_reg];
    assign s16 = {{(CoeffW - 4){1'b0}}, sample_reg[hsel], 4'b0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= 8'd24;
            lower_reg <= 8'd8;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_UPPER)
            begin
                upper_reg <= cfg_data;
            end
            else
            begin
                lower_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_heel_reg <= 1'b0;
            last_toe_reg <= 1'b0;
            hs_reg <= 1'b0;
            ts_reg <= 1'b0;
            to_reg <= 1'b0;
            heel_t_reg <= '0;
            tstr_t_reg <= '0;
            toff_t_reg <= '0;
            heel_cnt_reg <= '0;
            tstr_cnt_reg <= '0;
            toff_cnt_reg <= '0;
            for (int k = 0; k < NumHist; k++)
            begin
                need_reg[k] <= 1'b0;
                sample_reg[k] <= '0;
            end
        end
        else if (cmd.start)
        begin
            last_heel_reg <= heel_contact;
            last_toe_reg <= toe_contact;
            hs_reg <= hs;
            ts_reg <= ts;
            to_reg <= to;
            need_reg[H_STEP] <= hs && (heel_cnt_reg != 2'd0);
            need_reg[H_SWING] <= ts && (toff_cnt_reg == 2'd2);
            need_reg[H_STANCE] <= to && ((tstr_cnt_reg == 2'd2) ||
                                         (ts && tstr_cnt_reg == 2'd1));
            sample_reg[H_STEP] <= now_ms - heel_t_reg;
            sample_reg[H_SWING] <= now_ms - toff_t_reg;
            sample_reg[H_STANCE] <= now_ms - (ts ? now_ms : tstr_t_reg);
            if (hs)
            begin
                heel_t_reg <= now_ms;
                if (heel_cnt_reg != 2'd2)
                begin
                    heel_cnt_reg <= heel_cnt_reg + 2'd1;
                end
            end
            if (ts)
            begin
                tstr_t_reg <= now_ms;
                if (tstr_cnt_reg != 2'd2)
                begin
                    tstr_cnt_reg <= tstr_cnt_reg + 2'd1;
                end
            end
            if (to)
            begin
                toff_t_reg <= now_ms;
                if (toff_cnt_reg != 2'd2)
                begin
                    toff_cnt_reg <= toff_cnt_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            now_reg <= now_ms;
            heel_reg <= heel_contact;
            toe_reg <= toe_contact;
        end
    end

    assign stat.hist_needed = need_reg[hsel];
    assign stat.hist_done = hist_done;
    assign stat.div_done = div_done;

    // History update phases: scan min and max, form window products, shift and sum.
    localparam logic [1:0] HP_SCAN = 2'd0;
    localparam logic [1:0] HP_TEST = 2'd1;
    localparam logic [1:0] HP_SUM = 2'd2;
    localparam logic [1:0] HP_IDLE = 2'd3;

    assign hist_done = (hphase_reg == HP_SUM) &&
                       (!accept_reg || scan_reg == IdxW'(DepthU - 1));

    logic fill_short;
    assign fill_short = fill_reg[hsel] != FillW'(DepthU);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hphase_reg <= HP_IDLE;
            scan_reg <= '0;
            accept_reg <= 1'b0;
            for (int k = 0; k < NumHist; k++)
            begin
                fill_reg[k] <= '0;
                exp_reg[k] <= '0;
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    hist_reg[k][i] <= '0;
                end
            end
        end
        else if (cmd.hist_start)
        begin
            scan_reg <= '0;
            if (fill_short)
            begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                begin
                    hist_reg[hsel][i] <= hist_reg[hsel][i-1];
                end
                hist_reg[hsel][0] <= sample_reg[hsel];
                fill_reg[hsel] <= fill_reg[hsel] + FillW'(1);
                accept_reg <= 1'b0;
                hphase_reg <= HP_SUM;
            end
            else
            begin
                mx_reg <= hist_reg[hsel][0];
                mn_reg <= hist_reg[hsel][0];
                hphase_reg <= HP_SCAN;
            end
        end
        else
        begin
            case (hphase_reg)
                HP_SCAN:
                begin
                    if (cur_elem > mx_reg)
                    begin
                        mx_reg <= cur_elem;
                    end
                    if (cur_elem < mn_reg)
                    begin
                        mn_reg <= cur_elem;
                    end
                    if (scan_reg == IdxW'(DepthU - 1))
                    begin
                        hphase_reg <= HP_TEST;
                        scan_reg <= '0;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IdxW'(1);
                    end
                end
                HP_TEST:
                begin
                    up_prod_reg <= ProdW'(upper_reg * mx_reg);
                    lo_prod_reg <= ProdW'(lower_reg * mn_reg);
                    hphase_reg <= HP_IDLE;
                    accept_reg <= 1'b1;
                    scan_reg <= '1;
                end
                HP_IDLE:
                begin
                    if (accept_reg && scan_reg == '1)
                    begin
                        scan_reg <= '0;
                        if (s16 <= up_prod_reg && s16 >= lo_prod_reg)
                        begin
                            for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                            begin
                                hist_reg[hsel][i] <= hist_reg[hsel][i-1];
                            end
                            hist_reg[hsel][0] <= sample_reg[hsel];
                            sum_reg <= '0;
                            hphase_reg <= HP_SUM;
                        end
                        else
                        begin
                            accept_reg <= 1'b0;
                            hphase_reg <= HP_SUM;
                        end
                    end
                end
                HP_SUM:
                begin
                    if (accept_reg)
                    begin
                        if (scan_reg == IdxW'(DepthU - 1))
                        begin
                            exp_reg[hsel] <= TimeW'((sum_reg + SumW'(cur_elem))
                                                    / DepthU);
                            accept_reg <= 1'b0;
                            hphase_reg <= HP_IDLE;
                        end
                        else
                        begin
                            sum_reg <= sum_reg + SumW'(cur_elem);
                            scan_reg <= scan_reg + IdxW'(1);
                        end
                    end
                    else
                    begin
                        hphase_reg <= HP_IDLE;
                    end
                end
                default:
                begin
                    hphase_reg <= HP_IDLE;
                end
            endcase
        end
    end

    // Restoring divider: elapsed*1000 / expected, one quotient bit per cycle.
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] ev_time;
    logic [TimeW+1:0] trial;
    logic [PctW-1:0] pct_new;
    logic pct_ovf;

    always_comb
    begin
        case (dsel)
            H_STEP:   ev_time = heel_t_reg;
            H_STANCE: ev_time = tstr_t_reg;
            default:  ev_time = toff_t_reg;
        endcase
    end
    assign elapsed = now_reg - ev_time;
    assign trial = {div_rem_reg, div_num_reg[NumW-1]} - {2'b00, div_den_reg};
    assign pct_ovf = |div_num_reg[NumW-1:PctW] || div_num_reg[PctW-1:0] > PctMax;
    assign pct_new = pct_ovf ? PctMax : div_num_reg[PctW-1:0];
    assign div_done = div_busy_reg && div_cnt_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg <= '0;
            for (int k = 0; k < NumHist; k++)
            begin
                pct_reg[k] <= '0;
            end
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg <= DivCntW'(NumW);
            div_num_reg <= NumW'(elapsed * 10'd1000);
            div_rem_reg <= '0;
            div_den_reg <= exp_reg[dsel];
        end
        else if (div_busy_reg)
        begin
            if (div_cnt_reg == '0)
            begin
                div_busy_reg <= 1'b0;
                if (exp_reg[dsel] != '0)
                begin
                    pct_reg[dsel] <= pct_new;
                end
                if (dsel == H_STANCE && !heel_reg && !toe_reg)
                begin
                    pct_reg[dsel] <= '0;
                end
                if (dsel == H_SWING && (heel_reg || toe_reg))
                begin
                    pct_reg[dsel] <= '0;
                end
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg - DivCntW'(1);
                if (!trial[TimeW+1])
                begin
                    div_rem_reg <= trial[TimeW:0];
                    div_num_reg <= {div_num_reg[NumW-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= {div_rem_reg[TimeW-1:0], div_num_reg[NumW-1]};
                    div_num_reg <= {div_num_reg[NumW-2:0], 1'b0};
                end
            end
        end
    end

    assign heel_strike = hs_reg;
    assign toe_strike = ts_reg;
    assign toe_lift = to_reg;
    assign expected_step = exp_reg[H_STEP];
    assign expected_stance = exp_reg[H_STANCE];
    assign expected_swing = exp_reg[H_SWING];
    assign gait_percent = pct_reg[H_STEP];
    assign stance_percent = pct_reg[H_STANCE];
    assign swing_percent = pct_reg[H_SWING];
endmodule
